// ===== rtl/fat_cluster_chain_directory_defines.svh =====
// Assertion macros for the cluster chain directory.
// Depends on nothing; expects clk and rst_n in the including scope.
`ifndef FAT_CLUSTER_CHAIN_DIRECTORY_DEFINES_SVH
`define FAT_CLUSTER_CHAIN_DIRECTORY_DEFINES_SVH

// same-cycle implication
`define FCD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fcd assertion failed");

// next-cycle implication
`define FCD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fcd assertion failed");

`endif

// ===== rtl/fcd_pkg.sv =====
// Shared types and constants for the cluster chain directory.
// No dependencies.
package fcd_pkg;

  localparam int DIR_ENTRIES   = 4;
  localparam int TABLE_ENTRIES = 256;
  localparam int CLUSTER_BYTES = 4;
  localparam int DATA_BYTES    = TABLE_ENTRIES * CLUSTER_BYTES;
  localparam int DIR_W         = $clog2(DIR_ENTRIES);
  localparam int TBL_AW        = $clog2(TABLE_ENTRIES);
  localparam int DAT_AW        = $clog2(DATA_BYTES);

  localparam logic [15:0] END_MARK  = 16'hFFF8;
  localparam logic [15:0] FREED     = 16'h0001;
  localparam logic [11:0] BASE_YEAR = 12'd1980;

  typedef enum logic [2:0] {
    OP_WRITE  = 3'd0,
    OP_DELETE = 3'd1,
    OP_LOOKUP = 3'd2,
    OP_NEXT   = 3'd3,
    OP_DWRITE = 3'd4,
    OP_DREAD  = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NOTFOUND = 3'd1,
    ST_FULL     = 3'd2,
    ST_NOSPACE  = 3'd3,
    ST_BADCLUS  = 3'd4
  } status_t;

  typedef enum logic [10:0] {
    S_CLEAR     = 11'b000_0000_0001,
    S_IDLE      = 11'b000_0000_0010,
    S_CNT_RD    = 11'b000_0000_0100,
    S_CNT_CHK   = 11'b000_0000_1000,
    S_ALLOC_RD  = 11'b000_0001_0000,
    S_ALLOC_CHK = 11'b000_0010_0000,
    S_END_WR    = 11'b000_0100_0000,
    S_DEL_RD    = 11'b000_1000_0000,
    S_DEL_CHK   = 11'b001_0000_0000,
    S_MEM_CHK   = 11'b010_0000_0000,
    S_DONE      = 11'b100_0000_0000
  } state_t;

endpackage

// ===== rtl/fat_cluster_chain_directory.sv =====
// Top level of the cluster chain directory: sequencer, directory and stores.
// Depends on fcd_pkg, fcd_ram and fat_cluster_chain_directory_defines.svh.
//
// channel | signals                          | direction
// in      | in_valid/in_ready + op fields    | item in
// out     | out_valid/out_ready + results    | item out
//
// Reset starts a clearing pass over both stores; no item is taken meanwhile.
// One table read port serves all walks; count and allocation share one scan address.
// Write file: a free count over table entries 2 to 255, then an allocation walk from 2.
// Delete reads and checks each chain cluster; lookup and data write go straight to done.
// A finished result waits in the output register while the next item is accepted.
`include "fat_cluster_chain_directory_defines.svh"
module fat_cluster_chain_directory
  import fcd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_operation,
  input  logic [63:0] in_file_name,
  input  logic [15:0] in_byte_count,
  input  logic [11:0] in_year,
  input  logic [3:0]  in_month,
  input  logic [4:0]  in_day,
  input  logic [4:0]  in_hour,
  input  logic [5:0]  in_minute,
  input  logic [5:0]  in_second,
  input  logic [7:0]  in_cluster,
  input  logic [1:0]  in_byte_offset,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [7:0]  out_first_cluster,
  output logic [15:0] out_file_length,
  output logic [15:0] out_packed_date,
  output logic [15:0] out_packed_time,
  output logic [15:0] out_next_cluster,
  output logic        out_end_of_chain,
  output logic [7:0]  out_read_byte
);
  state_t state_r;
  logic [DAT_AW-1:0] clr_r;
  logic [TBL_AW-1:0] scan_r, prev_r, cur_r, first_r;
  logic [TBL_AW:0]   steps_r;
  logic [TBL_AW-1:0] free_cnt_r;
  logic [14:0]       need_r, got_r;
  logic [DIR_W-1:0]  slot_r;
  logic [63:0]       name_r;
  logic [15:0]       len_r, date_r, time_r;
  logic              op_next_r;

  logic [63:0] dir_name_r  [DIR_ENTRIES];
  logic [7:0]  dir_first_r [DIR_ENTRIES];
  logic [15:0] dir_len_r   [DIR_ENTRIES];
  logic [15:0] dir_date_r  [DIR_ENTRIES];
  logic [15:0] dir_time_r  [DIR_ENTRIES];

  logic [2:0]  p_status_r;
  logic [7:0]  p_first_r, p_rbyte_r;
  logic [15:0] p_len_r, p_date_r, p_time_r, p_next_r;
  logic        p_eoc_r;
  logic        out_valid_r;

  logic              tbl_we, dat_we;
  logic [TBL_AW-1:0] tbl_waddr, tbl_raddr;
  logic [15:0]       tbl_wdata, tbl_rdata;
  logic [DAT_AW-1:0] dat_waddr, dat_raddr;
  logic [7:0]        dat_wdata, dat_rdata;

  logic              accept, hit, has_slot, rd_free;
  logic [DIR_W-1:0]  hit_idx, free_idx;
  logic [16:0]       need_raw;
  logic [TBL_AW-1:0] cnt_new;

  fcd_ram #(.WIDTH(16), .DEPTH(TABLE_ENTRIES)) u_table (
    .clk(clk), .we(tbl_we), .waddr(tbl_waddr), .wdata(tbl_wdata),
    .raddr(tbl_raddr), .rdata(tbl_rdata)
  );

  fcd_ram #(.WIDTH(8), .DEPTH(DATA_BYTES)) u_data (
    .clk(clk), .we(dat_we), .waddr(dat_waddr), .wdata(dat_wdata),
    .raddr(dat_raddr), .rdata(dat_rdata)
  );

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign rd_free  = (tbl_rdata[15:1] == 15'd0);
  assign cnt_new  = free_cnt_r + TBL_AW'(rd_free);
  assign need_raw = (17'(in_byte_count) + 17'd3) >> 2;

  always_comb begin
    hit      = 1'b0;
    hit_idx  = '0;
    has_slot = 1'b0;
    free_idx = '0;
    for (int i = DIR_ENTRIES - 1; i >= 0; i--) begin
      if (in_file_name[7:0] != 8'd0 && dir_name_r[i] == in_file_name) begin
        hit     = 1'b1;
        hit_idx = DIR_W'(i);
      end
      if (dir_name_r[i][7:0] == 8'd0) begin
        has_slot = 1'b1;
        free_idx = DIR_W'(i);
      end
    end
  end

  always_comb begin
    tbl_we    = 1'b0;
    tbl_waddr = prev_r;
    tbl_wdata = END_MARK;
    dat_we    = 1'b0;
    dat_waddr = {in_cluster, in_byte_offset};
    dat_wdata = in_data_byte;
    unique case (state_r)
      S_CLEAR: begin
        tbl_we    = 1'b1;
        tbl_waddr = clr_r[TBL_AW-1:0];
        tbl_wdata = 16'd0;
        dat_we    = 1'b1;
        dat_waddr = clr_r;
        dat_wdata = 8'd0;
      end
      S_IDLE: dat_we = accept && (in_operation == OP_DWRITE);
      S_ALLOC_CHK: begin
        tbl_we    = rd_free && (got_r != 15'd0);
        tbl_wdata = 16'(scan_r);
      end
      S_END_WR: tbl_we = 1'b1;
      S_DEL_CHK: begin
        tbl_we    = 1'b1;
        tbl_waddr = cur_r;
        tbl_wdata = FREED;
      end
      default: ;
    endcase
  end

  always_comb begin
    dat_raddr = {in_cluster, in_byte_offset};
    unique case (state_r)
      S_IDLE:   tbl_raddr = in_cluster;
      S_DEL_RD: tbl_raddr = cur_r;
      default:  tbl_raddr = scan_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < DIR_ENTRIES; i++) begin
        dir_name_r[i]  <= '0;
        dir_first_r[i] <= '0;
        dir_len_r[i]   <= '0;
        dir_date_r[i]  <= '0;
        dir_time_r[i]  <= '0;
      end
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == DAT_AW'(DATA_BYTES - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            p_status_r <= ST_OK;
            p_first_r  <= '0;
            p_len_r    <= '0;
            p_date_r   <= '0;
            p_time_r   <= '0;
            p_next_r   <= '0;
            p_eoc_r    <= 1'b0;
            p_rbyte_r  <= '0;
            op_next_r  <= (in_operation == OP_NEXT);
            name_r     <= in_file_name;
            len_r      <= in_byte_count;
            date_r     <= {7'(in_year - BASE_YEAR), in_month, in_day};
            time_r     <= {in_hour, in_minute, in_second[5:1]};
            need_r     <= (need_raw == 17'd0) ? 15'd1 : need_raw[14:0];
            scan_r     <= TBL_AW'(2);
            free_cnt_r <= '0;
            got_r      <= '0;
            steps_r    <= '0;
            case (in_operation)
              OP_WRITE: state_r <= S_CNT_RD;
              OP_DELETE, OP_LOOKUP: begin
                if (!hit) begin
                  p_status_r <= ST_NOTFOUND;
                  state_r    <= S_DONE;
                end else if (in_operation == OP_LOOKUP) begin
                  p_first_r <= dir_first_r[hit_idx];
                  p_len_r   <= dir_len_r[hit_idx];
                  p_date_r  <= dir_date_r[hit_idx];
                  p_time_r  <= dir_time_r[hit_idx];
                  state_r   <= S_DONE;
                end else begin
                  dir_name_r[hit_idx] <= '0;
                  cur_r   <= dir_first_r[hit_idx];
                  state_r <= S_DEL_RD;
                end
              end
              OP_NEXT, OP_DREAD: state_r <= S_MEM_CHK;
              default: state_r <= S_DONE;
            endcase
            slot_r <= free_idx;
          end
        end
        S_CNT_RD: state_r <= S_CNT_CHK;
        S_CNT_CHK: begin
          free_cnt_r <= cnt_new;
          if (scan_r == TBL_AW'(TABLE_ENTRIES - 1)) begin
            scan_r <= TBL_AW'(2);
            if (15'(cnt_new) < need_r) begin
              p_status_r <= ST_NOSPACE;
              state_r    <= S_DONE;
            end else if (!has_slot) begin
              p_status_r <= ST_FULL;
              state_r    <= S_DONE;
            end else begin
              slot_r  <= free_idx;
              state_r <= S_ALLOC_RD;
            end
          end else begin
            scan_r  <= scan_r + 1'b1;
            state_r <= S_CNT_RD;
          end
        end
        S_ALLOC_RD: state_r <= S_ALLOC_CHK;
        S_ALLOC_CHK: begin
          scan_r  <= scan_r + 1'b1;
          state_r <= S_ALLOC_RD;
          if (rd_free) begin
            if (got_r == 15'd0) begin
              first_r <= scan_r;
            end
            prev_r <= scan_r;
            got_r  <= got_r + 1'b1;
            if (got_r + 15'd1 == need_r) begin
              state_r <= S_END_WR;
            end
          end
        end
        S_END_WR: begin
          dir_name_r[slot_r]  <= name_r;
          dir_first_r[slot_r] <= first_r;
          dir_len_r[slot_r]   <= len_r;
          dir_date_r[slot_r]  <= date_r;
          dir_time_r[slot_r]  <= time_r;
          p_first_r <= first_r;
          p_len_r   <= len_r;
          p_date_r  <= date_r;
          p_time_r  <= time_r;
          state_r   <= S_DONE;
        end
        S_DEL_RD: state_r <= S_DEL_CHK;
        S_DEL_CHK: begin
          steps_r <= steps_r + 1'b1;
          cur_r   <= tbl_rdata[TBL_AW-1:0];
          if (tbl_rdata == END_MARK || rd_free
              || tbl_rdata[15:TBL_AW] != '0
              || steps_r == (TBL_AW+1)'(TABLE_ENTRIES - 1)) begin
            state_r <= S_DONE;
          end else begin
            state_r <= S_DEL_RD;
          end
        end
        S_MEM_CHK: begin
          if (op_next_r) begin
            p_next_r <= tbl_rdata;
            p_eoc_r  <= (tbl_rdata == END_MARK);
          end else begin
            p_rbyte_r <= dat_rdata;
          end
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_CLEAR;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DONE && (!out_valid_r || out_ready)) begin
      out_status        <= p_status_r;
      out_first_cluster <= p_first_r;
      out_file_length   <= p_len_r;
      out_packed_date   <= p_date_r;
      out_packed_time   <= p_time_r;
      out_next_cluster  <= p_next_r;
      out_end_of_chain  <= p_eoc_r;
      out_read_byte     <= p_rbyte_r;
    end
  end

  assign out_valid = out_valid_r;

  `FCD_ASSERT_NOW(a_no_take_in_clear, state_r == S_CLEAR, !in_ready)
  `FCD_ASSERT_NEXT(a_busy_after_take, accept, !in_ready)
  `FCD_ASSERT_NOW(a_err_fields_zero, out_valid && out_status != ST_OK,
    out_first_cluster == 8'd0 && out_file_length == 16'd0 && out_read_byte == 8'd0)
endmodule

// ===== rtl/fcd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
